FILE: design/sfp_pkg.sv
// sfp_pkg: shared types and constants for the sync/type frame parser
// holds csr register indexes, reset values and the front-to-back command beat
// no dependencies
`timescale 1ns / 1ps

package sfp_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned LEN_W   = 7;
   localparam int unsigned INDEX_W = 6;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_VALUE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_TYPE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAYLOAD_LEN = 2'd2;

   localparam logic [BYTE_W-1:0] SYNC_VALUE_RST  = 8'd170;
   localparam logic [BYTE_W-1:0] FRAME_TYPE_RST  = 8'h01;
   localparam logic [LEN_W-1:0]  PAYLOAD_LEN_RST = 7'd16;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_EMIT  = 1'b1
   } cmd_kind_type;

   // one queue beat: a payload store write or a release of a verified frame
   typedef struct packed {
      cmd_kind_type        kind;
      logic [INDEX_W-1:0]  addr;
      logic [BYTE_W-1:0]   data;
      logic [LEN_W-1:0]    count;
   } cmd_type;

endpackage

FILE: design/sfp_queue.sv
// sfp_queue: two-entry command queue between parser front and emit back
// depends on sfp_pkg for the command beat type
`timescale 1ns / 1ps

module sfp_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  sfp_pkg::cmd_type push_data,
   input  logic            pop,
   output sfp_pkg::cmd_type pop_data,
   output logic            full,
   output logic            empty
);

   sfp_pkg::cmd_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset) full |-> !push)
      else $error("queue push while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset) empty |-> !pop)
      else $error("queue pop while empty");
`endif

endmodule

FILE: design/sfp_front.sv
// sfp_front: csr registers and frame parser (hunt, type, fill, checksum)
// depends on sfp_pkg; feeds store writes and frame releases to sfp_queue
`timescale 1ns / 1ps

module sfp_front #(
   parameter int unsigned MAX_PAYLOAD = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [sfp_pkg::BYTE_W-1:0]     req_rx_byte,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sfp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sfp_pkg::BYTE_W-1:0]     csr_wdata,
   input  logic                           q_full,
   output logic                           q_push,
   output sfp_pkg::cmd_type               q_push_data
);

   localparam logic [sfp_pkg::LEN_W-1:0] MaxLen = sfp_pkg::LEN_W'(MAX_PAYLOAD);

   typedef enum logic [1:0] {
      PH_HUNT  = 2'd0,
      PH_TYPE  = 2'd1,
      PH_FILL  = 2'd2,
      PH_CHECK = 2'd3
   } phase_type;

   phase_type                     phase_ff, phase_in;
   logic [sfp_pkg::LEN_W-1:0]     fill_ff, fill_in;
   logic [sfp_pkg::BYTE_W-1:0]    xor_ff, xor_in;
   logic [sfp_pkg::BYTE_W-1:0]    sync_value_ff;
   logic [sfp_pkg::BYTE_W-1:0]    frame_type_ff;
   logic [sfp_pkg::LEN_W-1:0]     payload_len_ff;
   logic [sfp_pkg::LEN_W-1:0]     eff_len;
   logic                          accept;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   always_comb begin
      if (payload_len_ff == '0) begin
         eff_len = sfp_pkg::LEN_W'(1);
      end else if (payload_len_ff > MaxLen) begin
         eff_len = MaxLen;
      end else begin
         eff_len = payload_len_ff;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      fill_in     = fill_ff;
      xor_in      = xor_ff;
      q_push      = 1'b0;
      q_push_data = '{kind: sfp_pkg::CMD_WRITE, addr: fill_ff[sfp_pkg::INDEX_W-1:0],
                      data: req_rx_byte, count: fill_ff};
      if (accept) begin
         case (phase_ff)
            PH_HUNT: begin
               if (req_rx_byte == sync_value_ff) begin
                  phase_in = PH_TYPE;
               end
            end
            PH_TYPE: begin
               if (req_rx_byte == frame_type_ff) begin
                  phase_in = PH_FILL;
                  fill_in  = '0;
                  xor_in   = '0;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_FILL: begin
               if (fill_ff < MaxLen) begin
                  q_push  = 1'b1;
                  xor_in  = xor_ff ^ req_rx_byte;
                  fill_in = fill_ff + 1'b1;
               end
               if (fill_in >= eff_len || fill_in >= MaxLen) begin
                  phase_in = PH_CHECK;
               end
            end
            PH_CHECK: begin
               if (req_rx_byte == xor_ff) begin
                  q_push           = 1'b1;
                  q_push_data.kind = sfp_pkg::CMD_EMIT;
               end
               phase_in = PH_HUNT;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT;
         fill_ff        <= '0;
         xor_ff         <= '0;
         sync_value_ff  <= sfp_pkg::SYNC_VALUE_RST;
         frame_type_ff  <= sfp_pkg::FRAME_TYPE_RST;
         payload_len_ff <= sfp_pkg::PAYLOAD_LEN_RST;
      end else begin
         phase_ff <= phase_in;
         fill_ff  <= fill_in;
         xor_ff   <= xor_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               sfp_pkg::CSR_SYNC_VALUE:  sync_value_ff  <= csr_wdata;
               sfp_pkg::CSR_FRAME_TYPE:  frame_type_ff  <= csr_wdata;
               sfp_pkg::CSR_PAYLOAD_LEN: payload_len_ff <= csr_wdata[sfp_pkg::LEN_W-1:0];
               default: ;
            endcase
         end
      end
   end

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= MaxLen)
      else $error("fill count beyond payload store");
`endif

endmodule

FILE: design/sfp_back.sv
// sfp_back: payload store and emit sequencer
// depends on sfp_pkg; drains commands from sfp_queue and drives the rsp beats
`timescale 1ns / 1ps

module sfp_back #(
   parameter int unsigned MAX_PAYLOAD = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_empty,
   input  sfp_pkg::cmd_type             q_pop_data,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [sfp_pkg::BYTE_W-1:0]   rsp_payload_byte,
   output logic [sfp_pkg::INDEX_W-1:0]  rsp_byte_index,
   output logic                         rsp_last
);

   localparam int unsigned AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EMIT = 1'b1
   } state_type;

   logic [sfp_pkg::BYTE_W-1:0]  store_mem [MAX_PAYLOAD];
   state_type                   state_ff;
   logic [sfp_pkg::LEN_W-1:0]   idx_ff;
   logic [sfp_pkg::LEN_W-1:0]   total_ff;
   logic                        rsp_valid_ff;
   logic [sfp_pkg::BYTE_W-1:0]  rsp_payload_ff;
   logic [sfp_pkg::INDEX_W-1:0] rsp_index_ff;
   logic                        rsp_last_ff;
   logic                        slot_free;
   logic                        is_last;
   logic                        store_we;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_payload_byte = rsp_payload_ff;
   assign rsp_byte_index   = rsp_index_ff;
   assign rsp_last         = rsp_last_ff;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign is_last   = (idx_ff + 1'b1) == total_ff;
   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign store_we  = q_pop && (q_pop_data.kind == sfp_pkg::CMD_WRITE);

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[q_pop_data.addr[AddrW-1:0]] <= q_pop_data.data;
      end
      if (state_ff == ST_EMIT && slot_free) begin
         rsp_payload_ff <= store_mem[idx_ff[AddrW-1:0]];
         rsp_index_ff   <= idx_ff[sfp_pkg::INDEX_W-1:0];
         rsp_last_ff    <= is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_EMIT && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (q_pop && q_pop_data.kind == sfp_pkg::CMD_EMIT) begin
                  idx_ff   <= '0;
                  total_ff <= q_pop_data.count;
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (slot_free) begin
                  idx_ff <= idx_ff + 1'b1;
                  if (is_last) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_emit_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (idx_ff < total_ff))
      else $error("emit index past frame length");
`endif

endmodule

FILE: design/sync_type_frame_parser_xor.sv
// sync_type_frame_parser_xor: top level of the sync/type framed parser with xor check
// depends on sfp_pkg, sfp_front, sfp_queue and sfp_back
`timescale 1ns / 1ps

// Takes one received byte per req beat. The parser hunts for the sync byte, checks the
// type byte, stores payload_len payload bytes (clamped to 1..MAX_PAYLOAD) with a running
// xor and compares the next byte with it. A good frame comes out on rsp as one beat per
// payload byte with its index, last set on the final byte; a bad frame gives nothing.
// The front takes one byte per cycle while the two-beat command queue has room. Each
// stored byte is one queue beat that the back retires while idle; a verified frame then
// holds the back in its emit state (one store read per rsp beat), so req may stall after
// a checksum byte. csr writes are always ready and are meant for idle periods only.

module sync_type_frame_parser_xor #(
   parameter int unsigned MAX_PAYLOAD = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [sfp_pkg::BYTE_W-1:0]     req_rx_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [sfp_pkg::BYTE_W-1:0]     rsp_payload_byte,
   output logic [sfp_pkg::INDEX_W-1:0]    rsp_byte_index,
   output logic                           rsp_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sfp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sfp_pkg::BYTE_W-1:0]     csr_wdata
);

   sfp_pkg::cmd_type push_data;
   sfp_pkg::cmd_type pop_data;
   logic             push;
   logic             pop;
   logic             full;
   logic             empty;

   sfp_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .q_full      (full),
      .q_push      (push),
      .q_push_data (push_data)
   );

   sfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (full),
      .empty     (empty)
   );

   sfp_back #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (empty),
      .q_pop_data       (pop_data),
      .q_pop            (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_last         (rsp_last)
   );

endmodule

FILE: tb/sv/sync_type_frame_parser_xor_test.sv
// sync_type_frame_parser_xor_test: self-checking bench for the sync/type frame parser
// drives bytes, predicts verified payload beats and checks rsp under random idle and stall
// depends on sfp_pkg and sync_type_frame_parser_xor
`timescale 1ns / 1ps

module sync_type_frame_parser_xor_test;

   localparam int unsigned MAX_PAYLOAD   = 64;
   localparam int unsigned SETTLE_CYCLES = 16;
   localparam int unsigned CYCLE_LIMIT   = 500000;

   typedef enum logic [1:0] {
      PARSE_HUNT  = 2'd0,
      PARSE_TYPE  = 2'd1,
      PARSE_FILL  = 2'd2,
      PARSE_CHECK = 2'd3
   } parse_phase_type;

   typedef struct packed {
      logic [sfp_pkg::BYTE_W-1:0]  data;
      logic [sfp_pkg::INDEX_W-1:0] index;
      logic                        last;
   } payload_beat_type;

   logic                          clock;
   logic                          reset       = 1'b1;
   logic                          req_valid   = 1'b0;
   logic                          req_stall;
   logic [sfp_pkg::BYTE_W-1:0]    req_rx_byte = '0;
   logic                          rsp_valid;
   logic                          rsp_stall   = 1'b0;
   logic [sfp_pkg::BYTE_W-1:0]    rsp_payload_byte;
   logic [sfp_pkg::INDEX_W-1:0]   rsp_byte_index;
   logic                          rsp_last;
   logic                          csr_valid   = 1'b0;
   logic                          csr_ready;
   logic [sfp_pkg::CSR_IDX_W-1:0] csr_index   = '0;
   logic [sfp_pkg::BYTE_W-1:0]    csr_wdata   = '0;

   // predictor state and its copy of the registers
   logic [sfp_pkg::BYTE_W-1:0]    cfg_sync    = sfp_pkg::SYNC_VALUE_RST;
   logic [sfp_pkg::BYTE_W-1:0]    cfg_type    = sfp_pkg::FRAME_TYPE_RST;
   logic [sfp_pkg::LEN_W-1:0]     cfg_len     = sfp_pkg::PAYLOAD_LEN_RST;
   parse_phase_type               parse_phase = PARSE_HUNT;
   int unsigned                   fill_count  = 0;
   logic [sfp_pkg::BYTE_W-1:0]    running_xor = '0;
   logic [sfp_pkg::BYTE_W-1:0]    frame_bytes [MAX_PAYLOAD];

   payload_beat_type     expected_payload [$];

   bit          sender_gaps  = 1'b1;
   bit          stall_gaps   = 1'b1;
   int unsigned stall_left   = 0;
   int unsigned cycle_count  = 0;
   int unsigned errors       = 0;
   int unsigned bytes_sent   = 0;
   int unsigned beats_seen   = 0;
   int unsigned good_frames  = 0;
   int unsigned csr_writes   = 0;

   sync_type_frame_parser_xor #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("sync_type_frame_parser_xor test failed");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int unsigned effective_len();
      int unsigned n;
      n = 32'(cfg_len);
      if (n < 1) n = 1;
      if (n > MAX_PAYLOAD) n = MAX_PAYLOAD;
      return n;
   endfunction

   task automatic parse_byte(input logic [sfp_pkg::BYTE_W-1:0] b);
      payload_beat_type beat;
      case (parse_phase)
         PARSE_HUNT: begin
            if (b == cfg_sync) parse_phase = PARSE_TYPE;
         end
         PARSE_TYPE: begin
            if (b == cfg_type) begin
               parse_phase = PARSE_FILL;
               fill_count  = 0;
               running_xor = '0;
            end else begin
               parse_phase = PARSE_HUNT;
            end
         end
         PARSE_FILL: begin
            if (fill_count < MAX_PAYLOAD) begin
               frame_bytes[fill_count[sfp_pkg::INDEX_W-1:0]] = b;
               running_xor = running_xor ^ b;
               fill_count++;
            end
            if (fill_count >= effective_len()) parse_phase = PARSE_CHECK;
         end
         default: begin
            if (b == running_xor) begin
               for (int unsigned i = 0; i < fill_count; i++) begin
                  beat.data  = frame_bytes[i[sfp_pkg::INDEX_W-1:0]];
                  beat.index = i[sfp_pkg::INDEX_W-1:0];
                  beat.last  = (i + 1 == fill_count);
                  expected_payload.push_back(beat);
               end
               good_frames++;
            end
            parse_phase = PARSE_HUNT;
         end
      endcase
   endtask

   task automatic send_byte(input logic [sfp_pkg::BYTE_W-1:0] b);
      int gap;
      gap = sender_gaps ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      parse_byte(b);
      bytes_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_payload.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // leaves csr_valid high; the caller lowers it after its last write
   task automatic write_csr(input logic [sfp_pkg::CSR_IDX_W-1:0] idx,
                            input logic [sfp_pkg::BYTE_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         sfp_pkg::CSR_SYNC_VALUE:  cfg_sync = data;
         sfp_pkg::CSR_FRAME_TYPE:  cfg_type = data;
         sfp_pkg::CSR_PAYLOAD_LEN: cfg_len  = data[sfp_pkg::LEN_W-1:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic set_config(input logic [sfp_pkg::BYTE_W-1:0] sync_b,
                             input logic [sfp_pkg::BYTE_W-1:0] type_b,
                             input logic [sfp_pkg::BYTE_W-1:0] len_b);
      write_csr(sfp_pkg::CSR_SYNC_VALUE, sync_b);
      write_csr(sfp_pkg::CSR_FRAME_TYPE, type_b);
      write_csr(sfp_pkg::CSR_PAYLOAD_LEN, len_b);
      csr_valid <= 1'b0;
   endtask

   // mostly well-formed frames, some with a bad checksum or type, some line noise
   task automatic run_frames(input int unsigned budget, input bit drain_each);
      int unsigned                stop_at;
      int                         kind;
      logic [sfp_pkg::BYTE_W-1:0] sum;
      logic [sfp_pkg::BYTE_W-1:0] b;
      stop_at = bytes_sent + budget;
      while (bytes_sent < stop_at) begin
         kind = $urandom_range(0, 99);
         if (kind < 88) begin
            send_byte(cfg_sync);
            if (kind >= 80) begin
               b = 8'($urandom);
               if (b == cfg_type) b = ~b;
               send_byte(b);
            end else begin
               send_byte(cfg_type);
               sum = '0;
               repeat (effective_len()) begin
                  b = 8'($urandom);
                  sum = sum ^ b;
                  send_byte(b);
               end
               if (kind >= 70) sum = sum ^ 8'($urandom_range(1, 255));
               send_byte(sum);
            end
         end else begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
         end
         if (drain_each) wait_drained();
      end
   endtask

   task automatic test_good_frame();
      write_csr(sfp_pkg::CSR_PAYLOAD_LEN, 8'd3);
      csr_valid <= 1'b0;
      // sync value inside the payload is plain data
      send_byte(cfg_sync);
      send_byte(cfg_type);
      send_byte(cfg_sync);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(cfg_sync ^ 8'hFF);
   endtask

   task automatic test_checksum_mismatch();
      wait_drained();
      write_csr(sfp_pkg::CSR_PAYLOAD_LEN, 8'd0);
      csr_valid <= 1'b0;
      send_byte(cfg_sync);
      send_byte(cfg_type);
      send_byte(8'h12);
      send_byte(8'h00);
      send_byte(cfg_sync);
      send_byte(cfg_type);
      send_byte(8'h7E);
      send_byte(8'h7E);
   endtask

   task automatic test_type_mismatch();
      // the rejected type byte must not restart the hunt as a sync
      send_byte(cfg_sync);
      send_byte(cfg_sync);
      send_byte(cfg_type);
      send_byte(8'h55);
      send_byte(8'h55);
   endtask

   task automatic test_length_change();
      wait_drained();
      write_csr(sfp_pkg::CSR_PAYLOAD_LEN, 8'd3);
      csr_valid <= 1'b0;
      send_byte(cfg_sync);
      send_byte(cfg_type);
      send_byte(8'h11);
      send_byte(8'h22);
      wait_drained();
      write_csr(sfp_pkg::CSR_PAYLOAD_LEN, 8'd1);
      csr_valid <= 1'b0;
      send_byte(8'h33);
      send_byte(8'h00);
   endtask

   task automatic test_reset_length();
      wait_drained();
      set_config(8'($urandom), 8'($urandom), {1'b0, sfp_pkg::PAYLOAD_LEN_RST});
      sender_gaps = 1'b0;
      stall_gaps  = 1'b0;
      run_frames(100, 1'b0);
      sender_gaps = 1'b1;
      stall_gaps  = 1'b1;
   endtask

   task automatic test_random_settings();
      logic [sfp_pkg::BYTE_W-1:0] sync_b;
      logic [sfp_pkg::BYTE_W-1:0] type_b;
      logic [sfp_pkg::BYTE_W-1:0] len_b;
      for (int k = 0; k < 6; k++) begin
         sync_b = (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : 8'($urandom);
         type_b = (k == 0) ? 8'hFF : (k == 1) ? 8'h00 : 8'($urandom);
         len_b  = (k == 2) ? 8'h81 : 8'($urandom_range(1, 8));
         wait_drained();
         set_config(sync_b, type_b, len_b);
         run_frames(40, 1'b0);
      end
   endtask

   task automatic test_max_length();
      wait_drained();
      set_config(8'($urandom), 8'($urandom), 8'd64);
      run_frames(60, 1'b0);
      wait_drained();
      set_config(8'($urandom), 8'($urandom), 8'hFF);
      run_frames(60, 1'b0);
   endtask

   task automatic test_back_pressure();
      wait_drained();
      set_config(8'($urandom), 8'($urandom), 8'($urandom_range(4, 16)));
      run_frames(60, 1'b1);
   endtask

   always @(posedge clock) begin : rsp_monitor
      int gap;
      payload_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_seen++;
         if (expected_payload.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected beat: byte %h index %0d last %b",
                        rsp_payload_byte, rsp_byte_index, rsp_last);
         end else begin
            want = expected_payload.pop_front();
            if (rsp_payload_byte !== want.data || rsp_byte_index !== want.index ||
                rsp_last !== want.last) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected byte %h index %0d last %b, got %h %0d %b",
                           want.data, want.index, want.last,
                           rsp_payload_byte, rsp_byte_index, rsp_last);
            end
         end
      end
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else begin
         gap = stall_gaps ? pick_gap() : 0;
         rsp_stall  <= (gap != 0);
         stall_left <= (gap != 0) ? gap - 1 : 0;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_good_frame();
      test_checksum_mismatch();
      test_type_mismatch();
      test_length_change();
      test_reset_length();
      test_random_settings();
      test_max_length();
      test_back_pressure();
      wait_drained();
      $display("sent %0d bytes over %0d register writes; %0d frames verified, %0d beats checked",
               bytes_sent, csr_writes, good_frames, beats_seen);
      if (errors == 0) begin
         $display("sync_type_frame_parser_xor test passed");
      end else begin
         $display("%0d mismatches", errors);
         $display("sync_type_frame_parser_xor test failed");
      end
      $finish;
   end

endmodule
